// ----- hdl/bottom_k_mean_depth_top_macros.svh -----
// Assertion macros for the bottom-k mean depth block.
// Used by bottom_k_mean_depth_top; no other dependencies.
`ifndef BOTTOM_K_MEAN_DEPTH_TOP_MACROS_SVH
`define BOTTOM_K_MEAN_DEPTH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BKMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bkmd assertion failed");
// Next-cycle implication.
`define BKMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bkmd assertion failed");
`else
`define BKMD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BKMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/bkmd_pkg.sv -----
// Shared types and constants for the bottom-k mean depth block.
// No dependencies; used by every module of the block.
package bkmd_pkg;

  localparam int MAX_KEEP_DEF    = 16;
  localparam int HEIGHT_BITS_DEF = 24;
  localparam int BOTTOM_N_BITS   = 5;
  localparam int STATUS_BITS     = 2;
  localparam int CFG_IDX_BITS    = 1;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TREE_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM_N    = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_HEIGHT = 2'd1,
    STAT_BAD_COUNT  = 2'd2
  } bkmd_status_t;

  typedef enum logic [2:0] {
    S_RUN,
    S_EVAL,
    S_SUM,
    S_DIV,
    S_OUT
  } bkmd_state_t;

  // Sorter control from the back-end sequencer.
  typedef struct packed {
    logic ins;    // insert a height into the cell chain
    logic shift;  // move every cell one place towards the head
    logic clear;  // empty the list at end of run
  } bkmd_sort_ctrl_t;

endpackage

// ----- hdl/bottom_k_mean_depth_top.sv -----
// Channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: height; tlast: last of run
// out_    | out | out_tvalid/tready   | tdata: status, base_height, depth, used_count
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Points are taken one per cycle while the queue has room and inserted into the cell chain in order.
// At the last point of a run the sequencer evaluates the configuration, sums the used cells
// as they drain through the head (the last summing state starts the divider), waits for the
// divider, then loads the output register; an error result skips summing and divide.
// A four-entry queue keeps taking points while the end-of-run work or a stalled
// output register holds the back end. Synchronous reset clears control state only.
// Top level of the bottom-k mean depth block: front queue, sorter cells, divider.
// Depends on bkmd_pkg, bkmd_front, bkmd_sorter, bkmd_divider and the macros header.
`include "bottom_k_mean_depth_top_macros.svh"

module bottom_k_mean_depth_top #(
  parameter int MAX_KEEP    = bkmd_pkg::MAX_KEEP_DEF,
  parameter int HEIGHT_BITS = bkmd_pkg::HEIGHT_BITS_DEF,
  localparam int IN_W       = ((HEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_FW     = 2 * HEIGHT_BITS + 1 + bkmd_pkg::STATUS_BITS +
                              bkmd_pkg::BOTTOM_N_BITS,
  localparam int OUT_W      = ((OUT_FW + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // [0] height
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // from bit 0: status, base_height, depth, used_count
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bkmd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HEIGHT_BITS-1:0]            cfg_data
);

  localparam int KW   = $clog2(MAX_KEEP + 1);
  localparam int SUMW = HEIGHT_BITS + KW;
  localparam int NB   = bkmd_pkg::BOTTOM_N_BITS;

  // configuration
  logic signed [HEIGHT_BITS-1:0] tree_height_r;
  logic [NB-1:0]                 avg_n_r;

  // front queue
  logic                   q_valid, q_pop, q_last;
  logic [HEIGHT_BITS-1:0] q_height;

  // sorter and divider
  bkmd_pkg::bkmd_sort_ctrl_t sort_ctrl;
  logic [HEIGHT_BITS-1:0]    head;
  logic [KW-1:0]             kept;
  logic                      div_start, div_done;
  logic [HEIGHT_BITS-1:0]    div_quo;

  // back-end sequencer
  bkmd_pkg::bkmd_state_t  state_r, state_nxt;
  bkmd_pkg::bkmd_status_t status_r, status_nxt;
  logic [KW-1:0]          used_r, used_nxt;
  logic [KW-1:0]          cnt_r, cnt_nxt;
  logic [SUMW-1:0]        sum_r, sum_nxt;
  logic [HEIGHT_BITS-1:0] base_r, base_nxt;
  logic [KW-1:0]          want;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  bkmd_pkg::bkmd_status_t out_status_r;
  logic [HEIGHT_BITS-1:0] out_base_r;
  logic [HEIGHT_BITS:0]   out_crown_r;
  logic [NB-1:0]          out_used_r;
  logic [HEIGHT_BITS:0]   crown;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_height_r <= '0;
      avg_n_r       <= NB'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bkmd_pkg::CFG_TREE_HEIGHT: tree_height_r <= cfg_data;
        bkmd_pkg::CFG_BOTTOM_N:    avg_n_r       <= cfg_data[NB-1:0];
        default: ;
      endcase
    end
  end

  bkmd_front #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (in_tvalid),
    .s_ready  (in_tready),
    .s_height (in_tdata[HEIGHT_BITS-1:0]),
    .s_last   (in_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_height (q_height),
    .q_last   (q_last)
  );

  bkmd_sorter #(
    .MAX_KEEP   (MAX_KEEP),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_sorter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (sort_ctrl),
    .ins_height (q_height),
    .head       (head),
    .kept       (kept)
  );

  bkmd_divider #(
    .MAX_KEEP   (MAX_KEEP),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (used_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // averaging count above capacity saturates
  assign want  = (int'(avg_n_r) > MAX_KEEP) ? KW'(MAX_KEEP) : KW'(avg_n_r);
  assign crown = {tree_height_r[HEIGHT_BITS-1], tree_height_r} -
                 {base_r[HEIGHT_BITS-1], base_r};

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    used_nxt        = used_r;
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    base_nxt        = base_r;
    q_pop           = 1'b0;
    sort_ctrl       = '0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state_r)
      bkmd_pkg::S_RUN: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          sort_ctrl.ins = 1'b1;
          if (q_last) begin
            state_nxt = bkmd_pkg::S_EVAL;
          end
        end
      end
      bkmd_pkg::S_EVAL: begin
        sort_ctrl.clear = 1'b1;
        sum_nxt         = '0;
        cnt_nxt         = '0;
        base_nxt        = '0;
        used_nxt        = '0;
        if (tree_height_r <= 0) begin
          status_nxt = bkmd_pkg::STAT_BAD_HEIGHT;
          state_nxt  = bkmd_pkg::S_OUT;
        end else if (avg_n_r == '0) begin
          status_nxt = bkmd_pkg::STAT_BAD_COUNT;
          state_nxt  = bkmd_pkg::S_OUT;
        end else begin
          status_nxt = bkmd_pkg::STAT_OK;
          used_nxt   = (want < kept) ? want : kept;
          state_nxt  = bkmd_pkg::S_SUM;
        end
      end
      bkmd_pkg::S_SUM: begin
        if (cnt_r == used_r) begin
          div_start = 1'b1;
          state_nxt = bkmd_pkg::S_DIV;
        end else begin
          sort_ctrl.shift = 1'b1;
          sum_nxt         = sum_r + {{KW{head[HEIGHT_BITS-1]}}, head};
          cnt_nxt         = cnt_r + 1'b1;
        end
      end
      bkmd_pkg::S_DIV: begin
        if (div_done) begin
          base_nxt  = div_quo;
          state_nxt = bkmd_pkg::S_OUT;
        end
      end
      bkmd_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = bkmd_pkg::S_RUN;
        end
      end
      default: begin
        state_nxt = bkmd_pkg::S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bkmd_pkg::S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    used_r   <= used_nxt;
    cnt_r    <= cnt_nxt;
    sum_r    <= sum_nxt;
    base_r   <= base_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_base_r   <= base_r;
      out_crown_r  <= (status_r == bkmd_pkg::STAT_OK) ? crown : '0;
      out_used_r   <= NB'(used_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_used_r, out_crown_r, out_base_r, out_status_r});

  `BKMD_ASSERT_NOW(a_kept_range, clk, rst_n, 1'b1, kept <= KW'(MAX_KEEP))
  `BKMD_ASSERT_NOW(a_err_fields_zero, clk, rst_n,
                   out_valid_r && (out_status_r != bkmd_pkg::STAT_OK),
                   (out_base_r == '0) && (out_used_r == '0) && (out_crown_r == '0))
  `BKMD_ASSERT_NOW(a_result_from_seq, clk, rst_n, $rose(out_valid_r),
                   $past(state_r == bkmd_pkg::S_OUT))
  `BKMD_ASSERT_NEXT(a_div_exit, clk, rst_n, state_r == bkmd_pkg::S_DIV,
                    (state_r == bkmd_pkg::S_DIV) || (state_r == bkmd_pkg::S_OUT))

endmodule

// ----- hdl/bkmd_front.sv -----
// Front end: accepts point transactions and queues height and last flag.
// Depends on bkmd_pkg for the queue depth.
module bkmd_front #(
  parameter int HEIGHT_BITS = bkmd_pkg::HEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  logic [HEIGHT_BITS-1:0] s_height,
  input  logic                   s_last,
  output logic                   q_valid,
  input  logic                   q_pop,
  output logic [HEIGHT_BITS-1:0] q_height,
  output logic                   q_last
);

  localparam int AW = bkmd_pkg::FIFO_AW;

  logic [HEIGHT_BITS:0]  mem_r [bkmd_pkg::FIFO_DEPTH];
  logic [AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]           count_r, count_nxt;
  logic                  push, pop;

  assign s_ready  = (count_r != (AW+1)'(bkmd_pkg::FIFO_DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = s_valid && s_ready;
  assign pop      = q_pop && q_valid;
  assign q_height = mem_r[rd_ptr_r][HEIGHT_BITS-1:0];
  assign q_last   = mem_r[rd_ptr_r][HEIGHT_BITS];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {s_last, s_height};
    end
  end

endmodule

// ----- hdl/bkmd_sorter.sv -----
// Compare-and-shift cell chain holding the smallest heights in ascending order.
// Depends on bkmd_pkg for the control struct.
module bkmd_sorter #(
  parameter int MAX_KEEP    = bkmd_pkg::MAX_KEEP_DEF,
  parameter int HEIGHT_BITS = bkmd_pkg::HEIGHT_BITS_DEF,
  localparam int KW         = $clog2(MAX_KEEP + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bkmd_pkg::bkmd_sort_ctrl_t ctrl,
  input  logic [HEIGHT_BITS-1:0]    ins_height,
  output logic [HEIGHT_BITS-1:0]    head,
  output logic [KW-1:0]             kept
);

  logic [HEIGHT_BITS-1:0] cell_r [MAX_KEEP];
  logic [MAX_KEEP-1:0]    le;
  logic [KW-1:0]          kept_r, kept_nxt;

  // le[i]: cell i is occupied and stays ahead of the new height (ties keep order).
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign le[i] = (KW'(i) < kept_r) &&
                   ($signed(cell_r[i]) <= $signed(ins_height));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (ctrl.shift) begin
        if (i < MAX_KEEP - 1) begin
          cell_r[i] <= cell_r[(i < MAX_KEEP - 1) ? i + 1 : i];
        end
      end else if (ctrl.ins && !le[i]) begin
        if (i == 0) begin
          cell_r[i] <= ins_height;
        end else if (le[(i > 0) ? i - 1 : 0]) begin
          cell_r[i] <= ins_height;
        end else begin
          cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    kept_nxt = kept_r;
    if (ctrl.clear) begin
      kept_nxt = '0;
    end else if (ctrl.ins && (kept_r != KW'(MAX_KEEP))) begin
      kept_nxt = kept_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
    end else begin
      kept_r <= kept_nxt;
    end
  end

  assign head = cell_r[0];
  assign kept = kept_r;

endmodule

// ----- hdl/bkmd_divider.sv -----
// Radix-2 restoring divider: signed sum over small unsigned count, toward zero.
// Depends on bkmd_pkg for default widths.
module bkmd_divider #(
  parameter int MAX_KEEP    = bkmd_pkg::MAX_KEEP_DEF,
  parameter int HEIGHT_BITS = bkmd_pkg::HEIGHT_BITS_DEF,
  localparam int KW         = $clog2(MAX_KEEP + 1),
  localparam int SUMW       = HEIGHT_BITS + KW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SUMW-1:0]        dividend,
  input  logic [KW-1:0]          divisor,
  output logic                   done,
  output logic [HEIGHT_BITS-1:0] quotient
);

  localparam int CW = $clog2(SUMW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            neg_r;
  logic [SUMW-1:0] quo_r;
  logic [KW-1:0]   rem_r;
  logic [KW-1:0]   div_r;
  logic [KW:0]     rem_sh;
  logic [KW:0]     rem_sub;
  logic            ge;
  logic [SUMW-1:0] quo_neg;
  logic [SUMW-1:0] dvd_neg;

  assign rem_sh  = {rem_r, quo_r[SUMW-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign quo_neg = -quo_r;
  assign dvd_neg = -dividend;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(SUMW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Dividend magnitude shifts out of quo_r as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUMW-1];
      quo_r <= dividend[SUMW-1] ? dvd_neg : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUMW-2:0], ge};
      rem_r <= ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? quo_neg[HEIGHT_BITS-1:0] : quo_r[HEIGHT_BITS-1:0];

endmodule

// ----- tb/tb_bottom_k_mean_depth_top.sv -----
// Self-checking testbench for bottom_k_mean_depth_top: streams runs of point heights, keeps
// its own sorted list of the lowest heights and checks every end-of-run result field by field.
// Depends on bkmd_pkg and the bottom_k_mean_depth_top RTL.
module tb_bottom_k_mean_depth_top;
  import bkmd_pkg::*;

  localparam int HB        = HEIGHT_BITS_DEF;
  localparam int KEEP      = MAX_KEEP_DEF;
  localparam int IN_W      = ((HB + 7) / 8) * 8;
  localparam int OUT_W     = ((2 * HB + 1 + STATUS_BITS + BOTTOM_N_BITS + 7) / 8) * 8;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_PTS = 85;
  localparam int SETTLE    = 100;
  localparam int HOLD_LEN  = 400;
  localparam int LIMIT     = 600000;
  localparam logic signed [HB-1:0] H_MAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] H_MIN = {1'b1, {(HB-1){1'b0}}};

  typedef struct {
    logic [HB-1:0] height;
    logic          last;
  } point_t;

  typedef struct {
    bkmd_status_t         status;
    logic signed [HB-1:0] base;
    logic signed [HB:0]   depth;
    logic [4:0]           used;
  } depth_res_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_W-1:0]         in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_W-1:0]        out_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [HB-1:0]           cfg_data = '0;

  // predictor state
  logic signed [HB-1:0] lowest [KEEP];
  int                   kept_n = 0;
  logic signed [HB-1:0] tree_h = '0;
  logic [4:0]           bot_n = 5'd1;

  point_t     pend_q [$];
  depth_res_t depth_due [$];
  point_t     nxt_pt;
  depth_res_t got;
  depth_res_t want;
  int         fails = 0;
  int         cyc = 0;
  bit         calm = 1'b0;
  int         hold_kick = 0;
  int         hold_seen = 0;
  int         hold_cnt = 0;

  bottom_k_mean_depth_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // insert into the ascending list; when full, only a height below the top entry gets in
  task automatic keep_lowest(input logic signed [HB-1:0] h);
    int pos;
    if (kept_n < KEEP) begin
      pos = kept_n;
      kept_n++;
    end else if (h < lowest[KEEP-1]) begin
      pos = KEEP - 1;
    end else begin
      return;
    end
    while (pos > 0 && lowest[pos-1] > h) begin
      lowest[pos] = lowest[pos-1];
      pos--;
    end
    lowest[pos] = h;
  endtask

  function automatic depth_res_t close_run();
    depth_res_t r;
    longint     sum;
    longint     base;
    int         n_want;
    int         n_used;
    r.status = STAT_OK;
    r.base   = '0;
    r.depth  = '0;
    r.used   = '0;
    if (tree_h <= 0) begin
      r.status = STAT_BAD_HEIGHT;
    end else if (bot_n == 0) begin
      r.status = STAT_BAD_COUNT;
    end else begin
      n_want = (bot_n > KEEP) ? KEEP : bot_n;
      n_used = (n_want < kept_n) ? n_want : kept_n;
      sum = 0;
      for (int i = 0; i < n_used; i++) sum += longint'(lowest[i]);
      base = (n_used > 0) ? sum / n_used : 0;
      r.base  = base[HB-1:0];
      r.depth = (HB+1)'(longint'(tree_h) - base);
      r.used  = n_used[4:0];
    end
    kept_n = 0;
    return r;
  endfunction

  // sender: each accepted point goes through the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        keep_lowest(in_tdata[HB-1:0]);
        if (in_tlast) depth_due.push_back(close_run());
      end
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          nxt_pt = pend_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt_pt.height;
          in_tlast  <= nxt_pt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_cnt  <= HOLD_LEN;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = bkmd_status_t'(out_tdata[1:0]);
        got.base   = out_tdata[HB+1:2];
        got.depth  = out_tdata[2*HB+2:HB+2];
        got.used   = out_tdata[2*HB+7:2*HB+3];
        if (depth_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d base=%0d depth=%0d used=%0d",
                   $time, got.status, got.base, got.depth, got.used);
          fails++;
        end else begin
          want = depth_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fails++;
          end
          if (got.base !== want.base) begin
            $display("%0t: base_height expected %0d actual %0d", $time, want.base, got.base);
            fails++;
          end
          if (got.depth !== want.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time, want.depth,
                     got.depth);
            fails++;
          end
          if (got.used !== want.used) begin
            $display("%0t: used_count expected %0d actual %0d", $time, want.used, got.used);
            fails++;
          end
        end
      end
      out_tready <= (hold_cnt > 0) ? 1'b0 : (calm || $urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [HB-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TREE_HEIGHT) tree_h = val;
    else bot_n = val[4:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [HB-1:0] th, input logic [HB-1:0] bn);
    cfg_write(CFG_TREE_HEIGHT, th);
    cfg_write(CFG_BOTTOM_N, bn);
  endtask

  task automatic add_pt(input logic [HB-1:0] h, input logic lst);
    point_t p;
    p.height = h;
    p.last   = lst;
    pend_q.push_back(p);
  endtask

  // wait until every queued point is sent and every result is back, then let the back end settle
  task automatic drain();
    do @(posedge clk); while (pend_q.size() != 0 || in_tvalid || depth_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [HB-1:0] pick_height(input int mode, input logic [HB-1:0] centre);
    case (mode)
      0:       return HB'($urandom());
      1:       return centre + HB'($urandom_range(0, 2000)) - HB'(1000);
      2:       return centre;
      default: begin
        case ($urandom_range(0, 4))
          0:       return H_MAX;
          1:       return H_MIN;
          2:       return '0;
          3:       return '1;
          default: return HB'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic add_random_runs(input int total, input bit short_runs);
    int            left;
    int            len;
    int            mode;
    logic [HB-1:0] centre;
    left = total;
    while (left > 0) begin
      if (short_runs) len = $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(17, 24);
      else len = $urandom_range(1, 16);
      if (len > left) len = left;
      mode = $urandom_range(0, 3);
      centre = HB'($urandom());
      for (int i = 0; i < len; i++) add_pt(pick_height(mode, centre), i == len - 1);
      left -= len;
    end
  endtask

  function automatic logic [HB-1:0] pick_tree();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? '0 : HB'($urandom) | H_MIN;
      1:       return ($urandom_range(0, 1) != 0) ? HB'(1) : H_MAX;
      default: return HB'($urandom_range(1, 8388607));
    endcase
  endfunction

  function automatic logic [HB-1:0] pick_count();
    logic [HB-1:0] v;
    v = HB'($urandom());
    if ($urandom_range(0, 3) != 0) v[4:0] = 5'($urandom_range(1, KEEP));
    else if ($urandom_range(0, 1) != 0) v[4:0] = '0;
    else v[4:0] = 5'($urandom_range(KEEP + 1, 31));
    return v;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: tree height zero gives a bad-height result
    @(negedge clk);
    add_pt(HB'(5), 1'b1);
    drain();

    set_regs(H_MAX, HB'(KEEP));
    @(negedge clk);
    add_pt(H_MIN, 1'b1);
    add_pt(H_MAX, 1'b1);
    add_pt(H_MAX, 1'b0);
    add_pt(H_MIN, 1'b0);
    add_pt('0, 1'b0);
    add_pt('1, 1'b0);
    add_pt(HB'(1), 1'b0);
    add_pt(H_MIN, 1'b0);
    add_pt(HB'(-2), 1'b0);
    add_pt(HB'(-2), 1'b0);
    add_pt(HB'(12345), 1'b0);
    add_pt(H_MAX, 1'b0);
    add_pt(HB'(-3), 1'b0);
    add_pt(HB'(777), 1'b1);
    drain();

    // zero bottom count with a valid tree height
    set_regs(HB'(1), '0);
    @(negedge clk);
    add_pt(HB'(100), 1'b0);
    add_pt(HB'(200), 1'b1);
    drain();

    // most negative tree height with a valid count gives a bad-height result
    set_regs(H_MIN, HB'(5));
    @(negedge clk);
    add_pt(HB'(3), 1'b1);
    drain();

    // high bits set on the count write, count 31 saturates
    set_regs(HB'(24'h123456), '1);
    @(negedge clk);
    add_pt(HB'(-7), 1'b0);
    add_pt(HB'(4), 1'b0);
    add_pt(HB'(-1), 1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_regs(pick_tree(), pick_count());
      if (ph == 1) set_regs(HB'($urandom_range(1, 8388607)), HB'($urandom_range(1, KEEP)));
      calm = (ph == 5);
      @(negedge clk);
      if (ph == 2) begin
        // hold the output off while short runs pile up behind it
        hold_kick = hold_kick + 1;
        add_random_runs(PHASE_PTS, 1'b1);
      end else begin
        add_random_runs(PHASE_PTS, 1'b0);
      end
      drain();
    end
    calm = 1'b0;

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- bottom_k_mean_depth_top.f -----
+incdir+hdl
hdl/bkmd_pkg.sv
hdl/bkmd_front.sv
hdl/bkmd_sorter.sv
hdl/bkmd_divider.sv
hdl/bottom_k_mean_depth_top.sv
tb/tb_bottom_k_mean_depth_top.sv
